@@ rtl/assert_macros.svh @@
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed");

// Antecedent implies consequent sequence, checked outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> cons) \
    else $error("assertion failed");

`endif

@@ rtl/ppt_pkg.sv @@
`default_nettype none

package ppt_pkg;

  localparam int unsigned COORD_WIDTH_DEF   = 32;
  localparam int unsigned ANGLE_WIDTH_DEF   = 16;
  localparam int unsigned CORDIC_STAGES_DEF = 16;

  // cos/sin are Q2.30, carried with headroom for CORDIC growth
  localparam int unsigned TRIG_W    = 34;
  localparam int unsigned TRIG_FRAC = 30;
  localparam int unsigned ATAN_LEN  = 24;

  localparam logic signed [TRIG_W-1:0] INV_GAIN = 34'sd652032874;

  localparam logic [1:0] CMD_ROTATE = 2'd0;
  localparam logic [1:0] CMD_POINT  = 2'd1;
  localparam logic [1:0] CMD_POSE   = 2'd2;

  // atan(2^-i) with a full turn = 2^32
  function automatic logic [31:0] atan_turn(input int unsigned i);
    logic [31:0] r;
    unique case (i)
      0:  r = 32'h20000000;
      1:  r = 32'h12E4051E;
      2:  r = 32'h09FB385B;
      3:  r = 32'h051111D4;
      4:  r = 32'h028B0D43;
      5:  r = 32'h0145D7E1;
      6:  r = 32'h00A2F61E;
      7:  r = 32'h00517C55;
      8:  r = 32'h0028BE53;
      9:  r = 32'h00145F2F;
      10: r = 32'h000A2F98;
      11: r = 32'h000517CC;
      12: r = 32'h00028BE6;
      13: r = 32'h000145F3;
      14: r = 32'h0000A2F9;
      15: r = 32'h0000517C;
      16: r = 32'h000028BE;
      17: r = 32'h0000145F;
      18: r = 32'h00000A2F;
      19: r = 32'h00000517;
      20: r = 32'h0000028B;
      21: r = 32'h00000145;
      22: r = 32'h000000A2;
      23: r = 32'h00000051;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/ppt_cordic.sv @@
`default_nettype none

// Quadrant fold, one register per CORDIC micro-rotation, then sign fix.
// A sideband word rides along with each item.
module ppt_cordic import ppt_pkg::*; #(
  parameter int unsigned ANGLE_WIDTH = ANGLE_WIDTH_DEF,
  parameter int unsigned STAGES      = CORDIC_STAGES_DEF,
  parameter int unsigned SB_W        = 1
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     valid_i,
  input  wire logic [ANGLE_WIDTH-1:0]   angle_i,
  input  wire logic [SB_W-1:0]          sb_i,
  output logic                          valid_o,
  output logic signed [TRIG_W-1:0]      cos_o,
  output logic signed [TRIG_W-1:0]      sin_o,
  output logic [SB_W-1:0]               sb_o
);

  localparam logic signed [TRIG_W-1:0] QUARTER     = 34'sh0_4000_0000;
  localparam logic signed [TRIG_W-1:0] NEG_QUARTER = -34'sh0_4000_0000;
  localparam logic signed [TRIG_W-1:0] HALF        = 34'sh0_8000_0000;

  logic signed [31:0]       turn;
  logic signed [TRIG_W-1:0] z_in, z_fold;
  logic                     flip;

  logic signed [TRIG_W-1:0] x_q [STAGES+1];
  logic signed [TRIG_W-1:0] y_q [STAGES+1];
  logic signed [TRIG_W-1:0] z_q [STAGES+1];
  logic                     flip_q [STAGES+1];
  logic [SB_W-1:0]          sb_q [STAGES+1];
  logic [STAGES:0]          vld_q;

  logic signed [TRIG_W-1:0] cos_q, sin_q;
  logic [SB_W-1:0]          sb_out_q;
  logic                     vld_out_q;

  assign turn = {angle_i, {(32-ANGLE_WIDTH){1'b0}}};
  assign z_in = TRIG_W'(turn);

  // beyond a quarter turn: rotate by a half turn and negate at the end
  always_comb begin
    z_fold = z_in;
    flip   = 1'b0;
    if (z_in > QUARTER) begin
      z_fold = z_in - HALF;
      flip   = 1'b1;
    end else if (z_in < NEG_QUARTER) begin
      z_fold = z_in + HALF;
      flip   = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      vld_out_q <= 1'b0;
    end else begin
      vld_q     <= {vld_q[STAGES-1:0], valid_i};
      vld_out_q <= vld_q[STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    x_q[0]    <= INV_GAIN;
    y_q[0]    <= '0;
    z_q[0]    <= z_fold;
    flip_q[0] <= flip;
    sb_q[0]   <= sb_i;
    for (int unsigned k = 0; k < STAGES; k++) begin
      flip_q[k+1] <= flip_q[k];
      sb_q[k+1]   <= sb_q[k];
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    localparam logic signed [TRIG_W-1:0] ATAN = TRIG_W'(atan_turn(i));
    always_ff @(posedge clk_i) begin
      if (z_q[i] >= 0) begin
        x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
        z_q[i+1] <= z_q[i] - ATAN;
      end else begin
        x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
        z_q[i+1] <= z_q[i] + ATAN;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cos_q    <= flip_q[STAGES] ? -x_q[STAGES] : x_q[STAGES];
    sin_q    <= flip_q[STAGES] ? -y_q[STAGES] : y_q[STAGES];
    sb_out_q <= sb_q[STAGES];
  end

  assign valid_o = vld_out_q;
  assign cos_o   = cos_q;
  assign sin_o   = sin_q;
  assign sb_o    = sb_out_q;

endmodule

`default_nettype wire

@@ rtl/ppt_combine.sv @@
`default_nettype none

// Rotation products, translation, round half up and saturation. Five stages:
// split products, product merge, cross sum, base add, clamp.
module ppt_combine import ppt_pkg::*; #(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int unsigned HEAD_W      = ANGLE_WIDTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          valid_i,
  input  wire logic signed [TRIG_W-1:0]      cos_i,
  input  wire logic signed [TRIG_W-1:0]      sin_i,
  input  wire logic signed [COORD_WIDTH-1:0] lx_i,
  input  wire logic signed [COORD_WIDTH-1:0] ly_i,
  input  wire logic signed [COORD_WIDTH-1:0] bx_i,
  input  wire logic signed [COORD_WIDTH-1:0] by_i,
  input  wire logic [HEAD_W-1:0]             heading_i,
  output logic                               valid_o,
  output logic signed [COORD_WIDTH-1:0]      out_x_o,
  output logic signed [COORD_WIDTH-1:0]      out_y_o,
  output logic [HEAD_W-1:0]                  heading_o,
  output logic                               overflow_o
);

  localparam int unsigned CW    = COORD_WIDTH;
  localparam int unsigned LO_W  = CW / 2;
  localparam int unsigned HI_W  = CW - LO_W;
  localparam int unsigned PH_W  = HI_W + TRIG_W;
  localparam int unsigned PL_W  = LO_W + 1 + TRIG_W;
  localparam int unsigned PF_W  = CW + TRIG_W;
  localparam int unsigned SUM_W = PF_W + 1;
  localparam int unsigned ACC_W = CW + TRIG_W + 2;
  localparam int unsigned TOP_W = ACC_W - (TRIG_FRAC + CW - 1);

  localparam logic [TRIG_FRAC-1:0] ROUND_HALF = {1'b1, {(TRIG_FRAC-1){1'b0}}};
  localparam logic signed [CW-1:0] MAXV = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] MINV = {1'b1, {(CW-1){1'b0}}};

  // product k: 0 lx*cos, 1 ly*sin, 2 lx*sin, 3 ly*cos
  logic signed [PH_W-1:0] ph_q [4];
  logic signed [PL_W-1:0] pl_q [4];
  logic signed [PF_W-1:0] pf_q [4];

  logic signed [CW-1:0]   bx_q [3];
  logic signed [CW-1:0]   by_q [3];
  logic [HEAD_W-1:0]      hd_q [4];
  logic [4:0]             vld_q;

  logic signed [SUM_W-1:0] sx_q, sy_q;
  logic signed [ACC_W-1:0] ax_q, ay_q;
  logic signed [CW+TRIG_FRAC-1:0] bterm_x, bterm_y;

  logic [TOP_W-1:0]       top_x, top_y;
  logic                   fit_x, fit_y;
  logic signed [CW-1:0]   sat_x, sat_y;

  logic signed [CW-1:0]   out_x_q, out_y_q;
  logic [HEAD_W-1:0]      out_hd_q;
  logic                   ovf_q;

  for (genvar k = 0; k < 4; k++) begin : g_prod
    localparam bit USE_Y   = (k == 1) || (k == 3);
    localparam bit USE_SIN = (k == 1) || (k == 2);

    logic signed [CW-1:0]     a;
    logic signed [TRIG_W-1:0] t;
    logic signed [HI_W-1:0]   a_hi;
    logic signed [LO_W:0]     a_lo;

    assign a    = USE_Y ? ly_i : lx_i;
    assign t    = USE_SIN ? sin_i : cos_i;
    assign a_hi = a[CW-1:LO_W];
    assign a_lo = {1'b0, a[LO_W-1:0]};

    always_ff @(posedge clk_i) begin
      ph_q[k] <= PH_W'(a_hi) * PH_W'(t);
      pl_q[k] <= PL_W'(a_lo) * PL_W'(t);
      pf_q[k] <= (PF_W'(ph_q[k]) <<< LO_W) + PF_W'(pl_q[k]);
    end
  end

  // translation term with the rounding half folded into its zero fraction
  assign bterm_x = {bx_q[2], ROUND_HALF};
  assign bterm_y = {by_q[2], ROUND_HALF};

  always_ff @(posedge clk_i) begin
    bx_q[0] <= bx_i;
    by_q[0] <= by_i;
    hd_q[0] <= heading_i;
    for (int unsigned k = 0; k < 2; k++) begin
      bx_q[k+1] <= bx_q[k];
      by_q[k+1] <= by_q[k];
    end
    for (int unsigned k = 0; k < 3; k++) begin
      hd_q[k+1] <= hd_q[k];
    end
    sx_q <= SUM_W'(pf_q[0]) - SUM_W'(pf_q[1]);
    sy_q <= SUM_W'(pf_q[2]) + SUM_W'(pf_q[3]);
    ax_q <= ACC_W'(sx_q) + ACC_W'(bterm_x);
    ay_q <= ACC_W'(sy_q) + ACC_W'(bterm_y);
  end

  // floor shift by the fraction; fits when the bits above agree with the sign
  assign top_x = ax_q[ACC_W-1:TRIG_FRAC+CW-1];
  assign top_y = ay_q[ACC_W-1:TRIG_FRAC+CW-1];
  assign fit_x = (&top_x) || !(|top_x);
  assign fit_y = (&top_y) || !(|top_y);
  assign sat_x = fit_x ? ax_q[TRIG_FRAC+CW-1:TRIG_FRAC] : (ax_q[ACC_W-1] ? MINV : MAXV);
  assign sat_y = fit_y ? ay_q[TRIG_FRAC+CW-1:TRIG_FRAC] : (ay_q[ACC_W-1] ? MINV : MAXV);

  always_ff @(posedge clk_i) begin
    out_x_q  <= sat_x;
    out_y_q  <= sat_y;
    out_hd_q <= hd_q[3];
    ovf_q    <= !fit_x || !fit_y;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  assign valid_o    = vld_q[4];
  assign out_x_o    = out_x_q;
  assign out_y_o    = out_y_q;
  assign heading_o  = out_hd_q;
  assign overflow_o = ovf_q;

endmodule

`default_nettype wire

@@ rtl/planar_pose_transform.sv @@
`default_nettype none

// Planar pose transform: rotates a local vector by the vehicle heading and,
// for points and poses, adds the vehicle position. Output heading is the
// wrapped sum of both headings for poses and zero otherwise.
//
// Input: drive command_i and the operand ports and raise start for one cycle.
// The item is taken at that edge whenever busy is low; busy never rises, so
// one item per clock is accepted with no gaps.
// Output: valid_o pulses for one cycle with out_x_o, out_y_o, out_heading_o
// and overflow_o once the item has passed the CORDIC pipe (fold, one register
// per stage, sign fix) and five multiply/add/saturate stages. Items leave in
// order, one per cycle at most.
// The receiver cannot stall; results must be captured when valid_o is high.
// Reset clears all valid bits, so nothing is emitted for items in flight.
// Coordinates saturate; overflow_o flags a clamped x or y.
module planar_pose_transform import ppt_pkg::*; #(
  parameter int unsigned COORD_WIDTH   = COORD_WIDTH_DEF,
  parameter int unsigned ANGLE_WIDTH   = ANGLE_WIDTH_DEF,
  parameter int unsigned CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [1:0]                    command_i,
  input  wire logic signed [COORD_WIDTH-1:0] local_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] local_y_i,
  input  wire logic signed [ANGLE_WIDTH-1:0] local_heading_i,
  input  wire logic signed [COORD_WIDTH-1:0] pose_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] pose_y_i,
  input  wire logic signed [ANGLE_WIDTH-1:0] pose_heading_i,
  output logic                               valid_o,
  output logic signed [COORD_WIDTH-1:0]      out_x_o,
  output logic signed [COORD_WIDTH-1:0]      out_y_o,
  output logic signed [ANGLE_WIDTH-1:0]      out_heading_o,
  output logic                               overflow_o
);

  localparam int unsigned CW      = COORD_WIDTH;
  localparam int unsigned SB_W    = ANGLE_WIDTH + 4 * CW;
  localparam int unsigned LATENCY = CORDIC_STAGES + 7;

  logic                     translate;
  logic [ANGLE_WIDTH-1:0]   head_sum;
  logic signed [CW-1:0]     base_x, base_y;
  logic [SB_W-1:0]          sb_in, sb_out;

  logic                     rot_valid;
  logic signed [TRIG_W-1:0] rot_cos, rot_sin;
  logic [ANGLE_WIDTH-1:0]   res_heading;

  assign busy      = 1'b0;
  assign translate = (command_i == CMD_POINT) || (command_i == CMD_POSE);
  assign head_sum  = (command_i == CMD_POSE) ?
                     ANGLE_WIDTH'(local_heading_i + pose_heading_i) : '0;
  assign base_x    = translate ? pose_x_i : '0;
  assign base_y    = translate ? pose_y_i : '0;
  assign sb_in     = {head_sum, local_x_i, local_y_i, base_x, base_y};

  ppt_cordic #(
    .ANGLE_WIDTH (ANGLE_WIDTH),
    .STAGES      (CORDIC_STAGES),
    .SB_W        (SB_W)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start && !busy),
    .angle_i (pose_heading_i),
    .sb_i    (sb_in),
    .valid_o (rot_valid),
    .cos_o   (rot_cos),
    .sin_o   (rot_sin),
    .sb_o    (sb_out)
  );

  ppt_combine #(
    .COORD_WIDTH (COORD_WIDTH),
    .HEAD_W      (ANGLE_WIDTH)
  ) u_combine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (rot_valid),
    .cos_i      (rot_cos),
    .sin_i      (rot_sin),
    .lx_i       (sb_out[4*CW-1:3*CW]),
    .ly_i       (sb_out[3*CW-1:2*CW]),
    .bx_i       (sb_out[2*CW-1:CW]),
    .by_i       (sb_out[CW-1:0]),
    .heading_i  (sb_out[SB_W-1:4*CW]),
    .valid_o    (valid_o),
    .out_x_o    (out_x_o),
    .out_y_o    (out_y_o),
    .heading_o  (res_heading),
    .overflow_o (overflow_o)
  );

  assign out_heading_o = res_heading;

endmodule

`default_nettype wire

@@ rtl/ppt_checker.sv @@
`default_nettype none

`include "assert_macros.svh"

module ppt_checker import ppt_pkg::*; #(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int unsigned ANGLE_WIDTH = ANGLE_WIDTH_DEF,
  parameter int unsigned LATENCY     = CORDIC_STAGES_DEF + 7
) (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          start,
  input wire logic                          busy,
  input wire logic [1:0]                    command_i,
  input wire logic                          valid_o,
  input wire logic signed [COORD_WIDTH-1:0] out_x_o,
  input wire logic signed [COORD_WIDTH-1:0] out_y_o,
  input wire logic signed [ANGLE_WIDTH-1:0] out_heading_o,
  input wire logic                          overflow_o
);

  localparam logic signed [COORD_WIDTH-1:0] MAXV = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] MINV = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  // every accepted item comes out after the fixed pipeline delay
  `ASSERT_IMPLY(a_latency, clk_i, rst_ni, start && !busy, ##LATENCY valid_o)

  // no result without an item taken the pipeline delay earlier
  `ASSERT_IMPLY(a_no_spurious, clk_i, rst_ni, valid_o, $past(start && !busy, LATENCY))

  // a nonzero heading only comes from a pose item
  `ASSERT_IMPLY(a_heading_pose, clk_i, rst_ni, valid_o && (out_heading_o != '0), $past(command_i, LATENCY) == CMD_POSE)

  // a clamped result sits on a range bound
  `ASSERT_IMPLY(a_ovf_bound, clk_i, rst_ni, valid_o && overflow_o, (out_x_o == MAXV) || (out_x_o == MINV) || (out_y_o == MAXV) || (out_y_o == MINV))

endmodule

bind planar_pose_transform ppt_checker #(
  .COORD_WIDTH (COORD_WIDTH),
  .ANGLE_WIDTH (ANGLE_WIDTH),
  .LATENCY     (LATENCY)
) u_ppt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .command_i     (command_i),
  .valid_o       (valid_o),
  .out_x_o       (out_x_o),
  .out_y_o       (out_y_o),
  .out_heading_o (out_heading_o),
  .overflow_o    (overflow_o)
);

`default_nettype wire
